FILE: sv/dh_forward_kinematics_top_macros.svh
// assertion macros for the forward kinematics block
// used by the top level only, no other dependencies
`ifndef DH_FORWARD_KINEMATICS_TOP_MACROS_SVH
`define DH_FORWARD_KINEMATICS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DHFK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dhfk: same-cycle check failed");
`define DHFK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dhfk: next-cycle check failed");
`else
`define DHFK_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DHFK_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/dhfk_pkg.sv
// shared types, constants and the arctangent table of the forward kinematics block
// no dependencies
package dhfk_pkg;

  localparam int JOINT_REGS = 6;
  localparam int ATAN_STEPS = 24;
  localparam int ANGLE_UP   = 18;
  localparam int JOINT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int Q28_W      = 32;
  localparam int ROT_W      = 16;
  localparam int POS_W      = 32;
  localparam int CNT_W      = 5;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [Q28_W-1:0] ONE_Q28 = 32'sd268435456;

  localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DH_JOINT_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DH_JOINT_5  = 3'd6;
  localparam logic [JOINT_W-1:0]   JOINT_COUNT_RST = 3'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_TRIG_T, S_TRIG_A, S_LINK, S_LINK_END,
    S_POS, S_POS_END, S_ROT, S_ROT_END, S_COMMIT, S_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_REDUCE, T_FOLD_TURN, T_FOLD_HALF, T_ITER, T_FINISH
  } trig_state_t;

  typedef enum logic [1:0] {MAC_NONE, MAC_LINK, MAC_POS, MAC_ROT} mac_op_t;

  typedef struct packed {
    logic               load_in;
    logic               init;
    logic               trig_start;
    logic               trig_twist;
    mac_op_t            mac_op;
    logic [1:0]         row;
    logic [1:0]         col;
    logic [1:0]         term;
    logic [JOINT_W-1:0] jsel;
    logic               commit;
    logic               load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic               trig_done;
    logic [JOINT_W-1:0] joints;
  } dp_status_t;

  function automatic logic signed [31:0] atan_q30(input logic [CNT_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sh3243F6A8;
      5'd1:    v = 32'sh1DAC6705;
      5'd2:    v = 32'sh0FADBAFC;
      5'd3:    v = 32'sh07F56EA6;
      5'd4:    v = 32'sh03FEAB76;
      5'd5:    v = 32'sh01FFD55B;
      5'd6:    v = 32'sh00FFFAAA;
      5'd7:    v = 32'sh007FFF55;
      5'd8:    v = 32'sh003FFFEA;
      5'd9:    v = 32'sh001FFFFD;
      5'd10:   v = 32'sh000FFFFF;
      5'd11:   v = 32'sh0007FFFF;
      5'd12:   v = 32'sh0003FFFF;
      5'd13:   v = 32'sh0001FFFF;
      5'd14:   v = 32'sh0000FFFF;
      5'd15:   v = 32'sh00007FFF;
      5'd16:   v = 32'sh00003FFF;
      5'd17:   v = 32'sh00001FFF;
      5'd18:   v = 32'sh00000FFF;
      5'd19:   v = 32'sh000007FF;
      5'd20:   v = 32'sh000003FF;
      5'd21:   v = 32'sh000001FF;
      5'd22:   v = 32'sh000000FF;
      5'd23:   v = 32'sh0000007F;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/dhfk_ifs.sv
// channel interfaces of the forward kinematics block: angles in, pose out, register writes
// depends on dhfk_pkg
interface dhfk_angles_if #(parameter int ANGLE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle_0;
  logic signed [ANGLE_BITS-1:0] angle_1;
  logic signed [ANGLE_BITS-1:0] angle_2;
  logic signed [ANGLE_BITS-1:0] angle_3;
  logic signed [ANGLE_BITS-1:0] angle_4;
  logic signed [ANGLE_BITS-1:0] angle_5;
  modport source (output valid, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
                  input ready);
  modport sink (input valid, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
                output ready);
endinterface

interface dhfk_pose_if;
  logic                               valid;
  logic                               ready;
  logic signed [dhfk_pkg::ROT_W-1:0] rot_00, rot_01, rot_02;
  logic signed [dhfk_pkg::ROT_W-1:0] rot_10, rot_11, rot_12;
  logic signed [dhfk_pkg::ROT_W-1:0] rot_20, rot_21, rot_22;
  logic signed [dhfk_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
  modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, output ready);
endinterface

interface dhfk_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dhfk_pkg::CFG_IDX_W-1:0]  index;
  logic [dhfk_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/dh_forward_kinematics_top.sv
// top level of the denavit-hartenberg forward kinematics block
// depends on dhfk_pkg, dhfk_ifs, dhfk_ctrl, dhfk_datapath and the macros header
//
// channels: angles (sink) takes one word of six joint angles, q3.12 radians;
// pose (source) returns one word per angles word: 3x3 rotation q1.14 and
// position q19.12, saturated; cfg (sink) writes joint_count (index 0) and the
// packed twist/length/offset of joints 0..5 (indices 1..6) and is always ready;
// the user must do such writes only while the block is idle, as it does not enforce this.
// one word is worked on at a time. for each joint in use the block makes two
// passes through the one cordic unit, then 42 products on the one shared
// multiplier (link, position, rotation), plus drain and commit states.
// the result sits in an output register; the next angles word is taken once
// the block is back in idle, and a finished pose waits in the register while
// the receiver stalls, holding back the word after it.
// reset (synchronous, active high) sets joint_count to 3, clears all joint
// registers and empties the output register.
`include "dh_forward_kinematics_top_macros.svh"

module dh_forward_kinematics_top #(
  parameter int MAX_JOINTS      = 6,
  parameter int ANGLE_BITS      = 16,
  parameter int LENGTH_BITS     = 24,
  parameter int TRIG_ITERATIONS = 16
) (
  input logic         clk,
  input logic         rst,
  dhfk_cfg_if.sink    cfg,
  dhfk_angles_if.sink angles,
  dhfk_pose_if.source pose
);

  dhfk_pkg::ctrl_cmd_t  cmd;
  dhfk_pkg::dp_status_t stat;
  logic in_ready;
  logic out_valid;

  assign angles.ready = in_ready;
  assign pose.valid   = out_valid;

  dhfk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (angles.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (pose.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dhfk_datapath #(
    .MAX_JOINTS      (MAX_JOINTS),
    .ANGLE_BITS      (ANGLE_BITS),
    .LENGTH_BITS     (LENGTH_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .angles (angles),
    .pose   (pose),
    .cmd    (cmd),
    .stat   (stat)
  );

  `DHFK_ASSERT_IMP(a_trig_no_mac, clk, rst, cmd.trig_start, cmd.mac_op == dhfk_pkg::MAC_NONE)
  `DHFK_ASSERT_NXT(a_busy_after_take, clk, rst, angles.valid && angles.ready, !angles.ready)
  `DHFK_ASSERT_NXT(a_load_shows_word, clk, rst, cmd.load_out, pose.valid)
  `DHFK_ASSERT_IMP(a_commit_busy, clk, rst, cmd.commit, !angles.ready && !cmd.load_out)

endmodule

FILE: sv/dhfk_cordic.sv
// iterative sine and cosine unit: angle reduction then rotation-mode cordic in q30
// depends on dhfk_pkg
module dhfk_cordic #(
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [ANGLE_BITS-1:0]  angle,
  output logic                          done,
  output logic signed [dhfk_pkg::Q28_W-1:0] sin_q,
  output logic signed [dhfk_pkg::Q28_W-1:0] cos_q
);

  localparam int WR  = ANGLE_BITS + 22;
  localparam int RED = (ANGLE_BITS > 15) ? ANGLE_BITS - 14 : 1;
  localparam int NIT = (TRIG_ITERATIONS < dhfk_pkg::ATAN_STEPS) ? TRIG_ITERATIONS
                                                                 : dhfk_pkg::ATAN_STEPS;
  localparam int XW  = 34;
  localparam int RW  = 36;

  dhfk_pkg::trig_state_t state;
  logic [dhfk_pkg::CNT_W-1:0] cnt;
  logic [WR-1:0]              mag;
  logic                       neg;
  logic                       flip;
  logic signed [RW-1:0]       r;
  logic signed [XW-1:0]       x, y;

  logic signed [WR-1:0] scaled;
  logic [WR-1:0]        two_w;
  logic [WR-1:0]        modv;
  logic signed [RW-1:0] r_s;
  logic signed [XW-1:0] dx, dy, xf, yf, xr, yr;
  logic signed [RW-1:0] at;

  always_comb begin
    scaled = WR'(angle) <<< dhfk_pkg::ANGLE_UP;
    two_w  = WR'(dhfk_pkg::TWO_PI_Q30);
    modv   = two_w << cnt;
    r_s    = neg ? -$signed(RW'(mag)) : $signed(RW'(mag));
    dx     = y >>> cnt;
    dy     = x >>> cnt;
    at     = RW'(dhfk_pkg::atan_q30(cnt));
    xf     = flip ? -x : x;
    yf     = flip ? -y : y;
    xr     = (xf + $signed(XW'(2))) >>> 2;
    yr     = (yf + $signed(XW'(2))) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dhfk_pkg::T_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        dhfk_pkg::T_IDLE: begin
          if (start) begin
            mag   <= angle[ANGLE_BITS-1] ? -scaled : scaled;
            neg   <= angle[ANGLE_BITS-1];
            cnt   <= dhfk_pkg::CNT_W'(RED - 1);
            state <= dhfk_pkg::T_REDUCE;
          end
        end
        dhfk_pkg::T_REDUCE: begin
          if (mag >= modv) mag <= mag - modv;
          if (cnt == '0) state <= dhfk_pkg::T_FOLD_TURN;
          else cnt <= cnt - 1'b1;
        end
        dhfk_pkg::T_FOLD_TURN: begin
          if (r_s > RW'(dhfk_pkg::PI_Q30)) r <= r_s - RW'(dhfk_pkg::TWO_PI_Q30);
          else if (r_s < -RW'(dhfk_pkg::PI_Q30)) r <= r_s + RW'(dhfk_pkg::TWO_PI_Q30);
          else r <= r_s;
          state <= dhfk_pkg::T_FOLD_HALF;
        end
        dhfk_pkg::T_FOLD_HALF: begin
          if (r > RW'(dhfk_pkg::HALF_PI_Q30)) begin
            r    <= r - RW'(dhfk_pkg::PI_Q30);
            flip <= 1'b1;
          end else if (r < -RW'(dhfk_pkg::HALF_PI_Q30)) begin
            r    <= r + RW'(dhfk_pkg::PI_Q30);
            flip <= 1'b1;
          end else begin
            flip <= 1'b0;
          end
          x     <= XW'(dhfk_pkg::GAIN_Q30);
          y     <= '0;
          cnt   <= '0;
          state <= dhfk_pkg::T_ITER;
        end
        dhfk_pkg::T_ITER: begin
          if (!r[RW-1]) begin
            x <= x - dx;
            y <= y + dy;
            r <= r - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            r <= r + at;
          end
          cnt <= cnt + 1'b1;
          if (cnt == dhfk_pkg::CNT_W'(NIT - 1)) state <= dhfk_pkg::T_FINISH;
        end
        dhfk_pkg::T_FINISH: begin
          cos_q <= xr[dhfk_pkg::Q28_W-1:0];
          sin_q <= yr[dhfk_pkg::Q28_W-1:0];
          done  <= 1'b1;
          state <= dhfk_pkg::T_IDLE;
        end
        default: state <= dhfk_pkg::T_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/dhfk_datapath.sv
// datapath: registers, trig unit, one shared multiplier with accumulator, pose and output words
// depends on dhfk_pkg, dhfk_ifs and dhfk_cordic
module dhfk_datapath #(
  parameter int MAX_JOINTS      = 6,
  parameter int ANGLE_BITS      = 16,
  parameter int LENGTH_BITS     = 24,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  dhfk_cfg_if.sink               cfg,
  dhfk_angles_if.sink            angles,
  dhfk_pose_if.source            pose,
  input  dhfk_pkg::ctrl_cmd_t    cmd,
  output dhfk_pkg::dp_status_t   stat
);

  localparam int QW  = dhfk_pkg::Q28_W;
  localparam int TW  = LENGTH_BITS + 2;
  localparam int MB  = (TW > QW) ? TW : QW;
  localparam int PRW = QW + MB;
  localparam int AW  = PRW + 2;
  localparam int PW  = (TW + 7 > 33) ? TW + 7 : 33;
  localparam int LIM = (MAX_JOINTS < dhfk_pkg::JOINT_REGS) ? MAX_JOINTS
                                                           : dhfk_pkg::JOINT_REGS;
  localparam logic signed [AW-1:0] HALF_Q28 = AW'(64'sd134217728);

  // configuration
  logic [dhfk_pkg::JOINT_W-1:0]    joint_count;
  logic [dhfk_pkg::CFG_DATA_W-1:0] dh_joint [dhfk_pkg::JOINT_REGS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= dhfk_pkg::JOINT_COUNT_RST;
      for (int i = 0; i < dhfk_pkg::JOINT_REGS; i++) dh_joint[i] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index) inside
        dhfk_pkg::REG_JOINT_COUNT:
          joint_count <= cfg.data[dhfk_pkg::JOINT_W-1:0];
        [dhfk_pkg::REG_DH_JOINT_0:dhfk_pkg::REG_DH_JOINT_5]:
          dh_joint[cfg.index - dhfk_pkg::REG_DH_JOINT_0] <= cfg.data;
        default: ;
      endcase
    end
  end

  assign stat.joints = (joint_count > dhfk_pkg::JOINT_W'(LIM)) ? dhfk_pkg::JOINT_W'(LIM)
                                                               : joint_count;

  // latched angles and per-joint fields
  logic signed [ANGLE_BITS-1:0] ang_q [dhfk_pkg::JOINT_REGS];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ang_q[0] <= angles.angle_0;
      ang_q[1] <= angles.angle_1;
      ang_q[2] <= angles.angle_2;
      ang_q[3] <= angles.angle_3;
      ang_q[4] <= angles.angle_4;
      ang_q[5] <= angles.angle_5;
    end
  end

  logic [127:0]                  ext;
  logic signed [ANGLE_BITS-1:0]  twist;
  logic signed [LENGTH_BITS-1:0] link_a, link_d;
  logic signed [ANGLE_BITS-1:0]  trig_in;

  always_comb begin
    ext     = {64'd0, dh_joint[cmd.jsel]};
    twist   = $signed(ext[2*LENGTH_BITS +: ANGLE_BITS]);
    link_a  = $signed(ext[LENGTH_BITS +: LENGTH_BITS]);
    link_d  = $signed(ext[0 +: LENGTH_BITS]);
    trig_in = cmd.trig_twist ? twist : ang_q[cmd.jsel];
  end

  // sine and cosine
  logic                 trig_done;
  logic signed [QW-1:0] trig_sin, trig_cos;
  logic                 trig_sel;
  logic signed [QW-1:0] st, ct, sa, ca;

  dhfk_cordic #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.trig_start),
    .angle (trig_in),
    .done  (trig_done),
    .sin_q (trig_sin),
    .cos_q (trig_cos)
  );

  assign stat.trig_done = trig_done;

  always_ff @(posedge clk) begin
    if (cmd.trig_start) trig_sel <= cmd.trig_twist;
    if (trig_done) begin
      if (trig_sel) begin
        sa <= trig_sin;
        ca <= trig_cos;
      end else begin
        st <= trig_sin;
        ct <= trig_cos;
      end
    end
  end

  // link transform, pose and next rotation
  logic signed [QW-1:0] j01, j02, j11, j12;
  logic signed [TW-1:0] t0, t1;
  logic signed [QW-1:0] jm [3][3];
  logic signed [TW-1:0] tv [3];
  logic signed [QW-1:0] rm [3][3];
  logic signed [QW-1:0] nm [3][3];
  logic signed [PW-1:0] p [3];

  always_comb begin
    jm[0][0] = ct;  jm[0][1] = j01; jm[0][2] = j02;
    jm[1][0] = st;  jm[1][1] = j11; jm[1][2] = j12;
    jm[2][0] = '0;  jm[2][1] = sa;  jm[2][2] = ca;
    tv[0] = t0;
    tv[1] = t1;
    tv[2] = TW'(link_d);
  end

  // multiplier stage
  logic signed [QW-1:0]  opa;
  logic signed [MB-1:0]  opb;
  logic signed [PRW-1:0] prod_q;
  dhfk_pkg::mac_op_t     tag_op;
  logic [1:0]            tag_row, tag_col, tag_term;

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.mac_op)
      dhfk_pkg::MAC_LINK: begin
        if (cmd.row == 2'd0) begin
          case (cmd.col)
            2'd0:    begin opa = st; opb = MB'(ca); end
            2'd1:    begin opa = st; opb = MB'(sa); end
            default: begin opa = ct; opb = MB'(ca); end
          endcase
        end else begin
          case (cmd.col)
            2'd0:    begin opa = ct; opb = MB'(sa); end
            2'd1:    begin opa = ct; opb = MB'(link_a); end
            default: begin opa = st; opb = MB'(link_a); end
          endcase
        end
      end
      dhfk_pkg::MAC_POS: begin
        opa = rm[cmd.row][cmd.term];
        opb = MB'(tv[cmd.term]);
      end
      dhfk_pkg::MAC_ROT: begin
        opa = rm[cmd.row][cmd.term];
        opb = MB'(jm[cmd.term][cmd.col]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_op <= dhfk_pkg::MAC_NONE;
    end else begin
      tag_op <= cmd.mac_op;
    end
    prod_q   <= opa * opb;
    tag_row  <= cmd.row;
    tag_col  <= cmd.col;
    tag_term <= cmd.term;
  end

  // accumulate stage
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_sum;
  logic signed [AW-1:0] rnd_full;
  logic signed [QW-1:0] q28;

  always_comb begin
    acc_sum  = ((tag_op == dhfk_pkg::MAC_LINK || tag_term == 2'd0) ? '0 : acc)
               + AW'(prod_q);
    rnd_full = (acc_sum + HALF_Q28) >>> 28;
    q28      = rnd_full[QW-1:0];
  end

  always_ff @(posedge clk) begin
    acc <= acc_sum;
    case (tag_op)
      dhfk_pkg::MAC_LINK: begin
        if (tag_row == 2'd0) begin
          case (tag_col)
            2'd0:    j01 <= -q28;
            2'd1:    j02 <= q28;
            default: j11 <= q28;
          endcase
        end else begin
          case (tag_col)
            2'd0:    j12 <= -q28;
            2'd1:    t0  <= rnd_full[TW-1:0];
            default: t1  <= rnd_full[TW-1:0];
          endcase
        end
      end
      dhfk_pkg::MAC_POS:
        if (tag_term == 2'd2) p[tag_row] <= p[tag_row] + rnd_full[PW-1:0];
      dhfk_pkg::MAC_ROT:
        if (tag_term == 2'd2) nm[tag_row][tag_col] <= q28;
      default: ;
    endcase
    if (cmd.init) begin
      for (int r = 0; r < 3; r++) begin
        p[r] <= '0;
        for (int k = 0; k < 3; k++) rm[r][k] <= (r == k) ? dhfk_pkg::ONE_Q28 : '0;
      end
    end else if (cmd.commit) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) rm[r][k] <= nm[r][k];
    end
  end

  // output word
  function automatic logic signed [dhfk_pkg::ROT_W-1:0] sat_rot(input logic signed [QW-1:0] v);
    logic signed [QW:0] w;
    w = ((QW+1)'(v) + $signed((QW+1)'(8192))) >>> 14;
    if (w > $signed((QW+1)'(32767))) return 16'sh7fff;
    else if (w < -$signed((QW+1)'(32768))) return 16'sh8000;
    else return w[dhfk_pkg::ROT_W-1:0];
  endfunction

  function automatic logic signed [dhfk_pkg::POS_W-1:0] sat_pos(input logic signed [PW-1:0] v);
    if (v > PW'(32'sh7fffffff)) return 32'sh7fffffff;
    else if (v < PW'(32'sh80000000)) return 32'sh80000000;
    else return v[dhfk_pkg::POS_W-1:0];
  endfunction

  logic signed [dhfk_pkg::ROT_W-1:0] out_rot [9];
  logic signed [dhfk_pkg::POS_W-1:0] out_pos [3];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int r = 0; r < 3; r++) begin
        out_pos[r] <= sat_pos(p[r]);
        for (int k = 0; k < 3; k++) out_rot[r*3+k] <= sat_rot(rm[r][k]);
      end
    end
  end

  assign pose.rot_00 = out_rot[0];
  assign pose.rot_01 = out_rot[1];
  assign pose.rot_02 = out_rot[2];
  assign pose.rot_10 = out_rot[3];
  assign pose.rot_11 = out_rot[4];
  assign pose.rot_12 = out_rot[5];
  assign pose.rot_20 = out_rot[6];
  assign pose.rot_21 = out_rot[7];
  assign pose.rot_22 = out_rot[8];
  assign pose.pos_x  = out_pos[0];
  assign pose.pos_y  = out_pos[1];
  assign pose.pos_z  = out_pos[2];

endmodule

FILE: sv/dhfk_ctrl.sv
// controller state machine: sequences joints, trig calls and multiply passes
// depends on dhfk_pkg
module dhfk_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dhfk_pkg::dp_status_t stat,
  output dhfk_pkg::ctrl_cmd_t  cmd
);

  dhfk_pkg::ctrl_state_t state, state_next;
  logic [dhfk_pkg::JOINT_W-1:0] j, j_next;
  logic [1:0] row, row_next, col, col_next, term, term_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dhfk_pkg::S_IDLE;
      j         <= '0;
      row       <= '0;
      col       <= '0;
      term      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      j         <= j_next;
      row       <= row_next;
      col       <= col_next;
      term      <= term_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    j_next         = j;
    row_next       = row;
    col_next       = col;
    term_next      = term;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mac_op     = dhfk_pkg::MAC_NONE;
    cmd.row        = row;
    cmd.col        = col;
    cmd.term       = term;
    cmd.jsel       = j;
    unique case (state)
      dhfk_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.init    = 1'b1;
          j_next      = '0;
          state_next  = dhfk_pkg::S_CHECK;
        end
      end
      dhfk_pkg::S_CHECK: begin
        if (j == stat.joints) begin
          state_next = dhfk_pkg::S_FINISH;
        end else begin
          cmd.trig_start = 1'b1;
          state_next     = dhfk_pkg::S_TRIG_T;
        end
      end
      dhfk_pkg::S_TRIG_T: begin
        if (stat.trig_done) begin
          cmd.trig_start = 1'b1;
          cmd.trig_twist = 1'b1;
          state_next     = dhfk_pkg::S_TRIG_A;
        end
      end
      dhfk_pkg::S_TRIG_A: begin
        cmd.trig_twist = 1'b1;
        if (stat.trig_done) begin
          row_next   = '0;
          col_next   = '0;
          term_next  = '0;
          state_next = dhfk_pkg::S_LINK;
        end
      end
      dhfk_pkg::S_LINK: begin
        cmd.mac_op = dhfk_pkg::MAC_LINK;
        if (col == 2'd2) begin
          col_next = '0;
          row_next = row + 1'b1;
          if (row == 2'd1) begin
            row_next   = '0;
            state_next = dhfk_pkg::S_LINK_END;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
      dhfk_pkg::S_LINK_END: state_next = dhfk_pkg::S_POS;
      dhfk_pkg::S_POS: begin
        cmd.mac_op = dhfk_pkg::MAC_POS;
        if (term == 2'd2) begin
          term_next = '0;
          row_next  = row + 1'b1;
          if (row == 2'd2) begin
            row_next   = '0;
            state_next = dhfk_pkg::S_POS_END;
          end
        end else begin
          term_next = term + 1'b1;
        end
      end
      dhfk_pkg::S_POS_END: state_next = dhfk_pkg::S_ROT;
      dhfk_pkg::S_ROT: begin
        cmd.mac_op = dhfk_pkg::MAC_ROT;
        if (term == 2'd2) begin
          term_next = '0;
          if (col == 2'd2) begin
            col_next = '0;
            row_next = row + 1'b1;
            if (row == 2'd2) begin
              row_next   = '0;
              state_next = dhfk_pkg::S_ROT_END;
            end
          end else begin
            col_next = col + 1'b1;
          end
        end else begin
          term_next = term + 1'b1;
        end
      end
      dhfk_pkg::S_ROT_END: state_next = dhfk_pkg::S_COMMIT;
      dhfk_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        j_next     = j + 1'b1;
        state_next = dhfk_pkg::S_CHECK;
      end
      dhfk_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = dhfk_pkg::S_IDLE;
        end
      end
      default: state_next = dhfk_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: test/tb_dhfk_scoreboard.sv
`timescale 1ns / 100ps
// pose scoreboard for the forward kinematics testbench: fixed-point predictor and result check
// depends on dhfk_pkg
package tb_dhfk_sb_pkg;

  typedef struct packed {
    logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [31:0] px, py, pz;
  } pose_t;

  localparam int N_ITER = 16;
  localparam longint PI_L = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint TWO_PI_L = 64'sd6746518852;
  localparam longint GAIN_L = 64'sd652032874;

  class pose_scoreboard;
    logic [2:0] joints_cfg;
    logic [63:0] link_cfg[6];
    pose_t pending[$];
    int errors;

    function new();
      joints_cfg = dhfk_pkg::JOINT_COUNT_RST;
      foreach (link_cfg[i]) link_cfg[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      if (idx == dhfk_pkg::REG_JOINT_COUNT) joints_cfg = val[2:0];
      else if (idx >= dhfk_pkg::REG_DH_JOINT_0 && idx <= dhfk_pkg::REG_DH_JOINT_5)
        link_cfg[idx - dhfk_pkg::REG_DH_JOINT_0] = val;
    endfunction

    static function longint rnd(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    static function void cordic(longint ang, output longint s, output longint c);
      longint r, x, y, dx, dy;
      bit flip;
      r = (ang * (64'sd1 <<< 18)) % TWO_PI_L;
      x = GAIN_L;
      y = 0;
      flip = 0;
      if (r > PI_L) r -= TWO_PI_L;
      else if (r < -PI_L) r += TWO_PI_L;
      if (r > HALF_PI_L) begin
        r -= PI_L;
        flip = 1;
      end else if (r < -HALF_PI_L) begin
        r += PI_L;
        flip = 1;
      end
      for (int i = 0; i < N_ITER; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (r >= 0) begin
          x -= dx;
          y += dy;
          r -= longint'(dhfk_pkg::atan_q30(dhfk_pkg::CNT_W'(i)));
        end else begin
          x += dx;
          y -= dy;
          r += longint'(dhfk_pkg::atan_q30(dhfk_pkg::CNT_W'(i)));
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = rnd(x, 2);
      s = rnd(y, 2);
    endfunction

    static function logic signed [15:0] sat16(longint v);
      return v < -32768 ? -16'sd32768 : (v > 32767 ? 16'sd32767 : v[15:0]);
    endfunction

    static function logic signed [31:0] sat32(longint v);
      return v < -64'sd2147483648 ? 32'h80000000 :
             (v > 64'sd2147483647 ? 32'h7fffffff : v[31:0]);
    endfunction

    function void note_angles(logic signed [15:0] ang[6]);
      longint rm[3][3], nm[3][3], lm[3][3], t[3], p[3], st, ct, sa, ca, a, d, acc;
      int n;
      pose_t e;
      n = joints_cfg > 6 ? 6 : joints_cfg;
      p = '{0, 0, 0};
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) rm[r][k] = (r == k) ? (64'sd1 <<< 28) : 0;
      for (int j = 0; j < n; j++) begin
        cordic(longint'(ang[j]), st, ct);
        cordic(longint'($signed(link_cfg[j][63:48])), sa, ca);
        a = longint'($signed(link_cfg[j][47:24]));
        d = longint'($signed(link_cfg[j][23:0]));
        lm[0] = '{ct, -rnd(st * ca, 28), rnd(st * sa, 28)};
        lm[1] = '{st, rnd(ct * ca, 28), -rnd(ct * sa, 28)};
        lm[2] = '{0, sa, ca};
        t = '{rnd(a * ct, 28), rnd(a * st, 28), d};
        for (int r = 0; r < 3; r++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += rm[r][k] * t[k];
          p[r] += rnd(acc, 28);
        end
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++)
            nm[r][k] = rnd(rm[r][0] * lm[0][k] + rm[r][1] * lm[1][k] + rm[r][2] * lm[2][k], 28);
        rm = nm;
      end
      e.r00 = sat16(rnd(rm[0][0], 14)); e.r01 = sat16(rnd(rm[0][1], 14));
      e.r02 = sat16(rnd(rm[0][2], 14)); e.r10 = sat16(rnd(rm[1][0], 14));
      e.r11 = sat16(rnd(rm[1][1], 14)); e.r12 = sat16(rnd(rm[1][2], 14));
      e.r20 = sat16(rnd(rm[2][0], 14)); e.r21 = sat16(rnd(rm[2][1], 14));
      e.r22 = sat16(rnd(rm[2][2], 14));
      e.px = sat32(p[0]); e.py = sat32(p[1]); e.pz = sat32(p[2]);
      pending.push_back(e);
    endfunction

    function void cmp(string nm, longint e, longint g);
      if (e != g) begin
        $error("%s expected %0d got %0d", nm, e, g);
        errors++;
      end
    endfunction

    function void check_pose(pose_t g);
      pose_t e;
      if (pending.size() == 0) begin
        $error("pose word with no expectation waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("rot_00", e.r00, g.r00); cmp("rot_01", e.r01, g.r01); cmp("rot_02", e.r02, g.r02);
      cmp("rot_10", e.r10, g.r10); cmp("rot_11", e.r11, g.r11); cmp("rot_12", e.r12, g.r12);
      cmp("rot_20", e.r20, g.r20); cmp("rot_21", e.r21, g.r21); cmp("rot_22", e.r22, g.r22);
      cmp("pos_x", e.px, g.px); cmp("pos_y", e.py, g.py); cmp("pos_z", e.pz, g.pz);
    endfunction
  endclass
endpackage

FILE: test/tb_dh_forward_kinematics_top.sv
`timescale 1ns / 100ps
// testbench top of the forward kinematics block: random angles and link settings, checked
// depends on dhfk_pkg, dhfk_ifs, tb_dhfk_scoreboard and the block itself
module tb_dh_forward_kinematics_top;

  logic clk = 0;
  logic rst = 1;
  dhfk_cfg_if cfg ();
  dhfk_angles_if angles ();
  dhfk_pose_if pose ();
  tb_dhfk_sb_pkg::pose_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  dh_forward_kinematics_top DUT (.clk(clk), .rst(rst), .cfg(cfg), .angles(angles), .pose(pose));

  initial forever #4 clk = ~clk;

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    cfg.valid = 0; cfg.index = '0; cfg.data = '0;
    angles.valid = 0;
    angles.angle_0 = 0; angles.angle_1 = 0; angles.angle_2 = 0;
    angles.angle_3 = 0; angles.angle_4 = 0; angles.angle_5 = 0;
    pose.ready = 0;
  end

  function automatic logic [2:0] joint_reg(int k);
    return dhfk_pkg::CFG_IDX_W'(int'(dhfk_pkg::REG_DH_JOINT_0) + k);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, val);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_angles(logic signed [15:0] a[6]);
    while (!no_idle && $urandom_range(99) < 34) begin
      angles.valid <= 0;
      @(posedge clk);
    end
    angles.valid <= 1;
    angles.angle_0 <= a[0]; angles.angle_1 <= a[1]; angles.angle_2 <= a[2];
    angles.angle_3 <= a[3]; angles.angle_4 <= a[4]; angles.angle_5 <= a[5];
    do @(posedge clk); while (!angles.ready);
    sb.note_angles(a);
  endtask

  task automatic drain();
    angles.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_link(bit wide);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (!wide) begin
      v[47:24] = 24'($signed(v[34:24]));
      v[23:0] = 24'($signed(v[10:0]));
    end
    return v;
  endfunction

  task automatic setup(int jc, bit wide);
    write_reg(dhfk_pkg::REG_JOINT_COUNT, 64'(jc));
    for (int i = 0; i < 6; i++) write_reg(joint_reg(i), rand_link(wide));
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (pose.valid && pose.ready)
        sb.check_pose({pose.rot_00, pose.rot_01, pose.rot_02, pose.rot_10, pose.rot_11,
                       pose.rot_12, pose.rot_20, pose.rot_21, pose.rot_22,
                       pose.pos_x, pose.pos_y, pose.pos_z});
      pose.ready <= !hold_off && (no_idle || $urandom_range(99) >= 34);
    end
  end

  initial begin
    logic signed [15:0] a[6];
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // defaults first: three joints, all links zero
    a = '{16'sh7fff, 16'sh8000, 0, 1, -1, 16'sh1922};
    send_angles(a);
    drain();
    write_reg(dhfk_pkg::REG_JOINT_COUNT, 64'd0);
    send_angles(a);
    drain();
    write_reg(dhfk_pkg::REG_JOINT_COUNT, 64'd7);
    write_reg(joint_reg(0), 64'h7fff_7fffff_7fffff);
    write_reg(joint_reg(1), 64'h8000_800000_800000);
    write_reg(joint_reg(2), 64'hffff_7fffff_800000);
    write_reg(joint_reg(3), 64'h1922_7fffff_7fffff);
    write_reg(joint_reg(4), 64'h0000_7fffff_7fffff);
    write_reg(joint_reg(5), 64'he6de_7fffff_800000);
    for (int i = 0; i < 8; i++) begin
      foreach (a[k]) a[k] = (i < 2) ? (i ? 16'sh8000 : 16'sh7fff) : rand_angle();
      send_angles(a);
    end
    drain();
    for (int ph = 0; ph < 11; ph++) begin
      setup(ph % 8, ph % 3 == 0);
      no_idle = (ph == 4);
      for (int i = 0; i < 50; i++) begin
        if (ph == 2 && i == 5) hold_off = 1;
        foreach (a[k]) a[k] = rand_angle();
        send_angles(a);
      end
      drain();
    end
    no_idle = 0;
    stim_done = 1;
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (hold_off);
    repeat (3000) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    wait (stim_done);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
